>>> hw/rtl/wgm_pkg.sv
// wgm_pkg: shared types and constants for the waveform grid minimizer
// payload structs, sample memory entry, config register codes, state enums
// no dependencies
package wgm_pkg;

	localparam int TIME_W     = 32;
	localparam int AMP_W      = 24;
	localparam int PHASE_W    = 32;
	localparam int Y_W        = 33;
	localparam int PTOL_W     = 31;
	localparam int MASK_W     = 64;
	localparam int WIDX_W     = 6;
	localparam int KCNT_W     = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_AMP_TOL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TOL = 2'd1;
	localparam logic [PTOL_W-1:0]    TOL_RESET     = 31'd168;

	typedef struct packed {
		logic [TIME_W-1:0]         sample_time;
		logic [AMP_W-1:0]          amplitude;
		logic signed [PHASE_W-1:0] phase;
		logic                      last_sample;
	} wgm_in_t;

	typedef struct packed {
		logic [MASK_W-1:0] keep_mask;
		logic [WIDX_W-1:0] mask_word_index;
		logic [KCNT_W-1:0] kept_count;
		logic              last_word;
	} wgm_out_t;

	typedef struct packed {
		logic [TIME_W-1:0]         sample_time;
		logic [AMP_W-1:0]          amplitude;
		logic signed [PHASE_W-1:0] phase;
	} wgm_samp_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_CLR, ST_MK0, ST_MKL, ST_MK_RD, ST_MK_WR,
		ST_C_INIT, ST_C_LOOP, ST_H_A, ST_H_UPCHK, ST_H_UP, ST_H_DN,
		ST_H_BIS, ST_H_BM, ST_C_NEXT,
		ST_F_INIT, ST_F_TOP, ST_F_BKCHK, ST_F_BK, ST_F_FWCHK, ST_F_FW,
		ST_F_TEST, ST_F_RES, ST_F_ADV,
		ST_E_RA, ST_E_RB, ST_E_RK, ST_E_K, ST_E_PS, ST_E_PW, ST_E_PH,
		ST_E_AW, ST_E_AM1, ST_E_AM2,
		ST_O_RD, ST_O_LD, ST_O_HOLD
	} wgm_state_t;

	typedef enum logic [2:0] {
		LP_IDLE, LP_SETUP, LP_PREP, LP_MUL, LP_DIV, LP_FIN, LP_DONE
	} wgm_lerp_state_t;

endpackage

>>> hw/rtl/wgm_lerp.sv
// wgm_lerp: iterative linear interpolation y0 + sign(dy)*floor(|dy|*dm/dt)
// shift-add multiply then restoring divide, one bit per cycle
// depends on wgm_pkg
module wgm_lerp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [wgm_pkg::Y_W-1:0]     y0,
	input  logic signed [wgm_pkg::Y_W-1:0]     y1,
	input  logic [wgm_pkg::TIME_W-1:0]         t0,
	input  logic [wgm_pkg::TIME_W-1:0]         t1,
	input  logic [wgm_pkg::TIME_W-1:0]         tm,
	output logic                               done,
	output logic signed [wgm_pkg::Y_W-1:0]     v
);
	import wgm_pkg::*;

	localparam int SW = $clog2(TIME_W);

	wgm_lerp_state_t st_q, st_d;
	logic [SW-1:0] cnt_q;

	logic signed [Y_W-1:0] y0_q, y1_q, v_q;
	logic [TIME_W-1:0] t0_q, t1_q, tm_q, dt_q, dm_q, mag_q;
	logic signed [Y_W:0] dy_q;
	logic neg_q;
	logic [2*TIME_W-1:0] p_q;

	logic [TIME_W:0] msum, dtrial;
	logic dge;

	assign msum   = {1'b0, p_q[2*TIME_W-1:TIME_W]} + (p_q[0] ? {1'b0, mag_q} : '0);
	assign dtrial = {p_q[2*TIME_W-1:TIME_W], p_q[TIME_W-1]};
	assign dge    = dtrial >= {1'b0, dt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= LP_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == LP_MUL || st_q == LP_DIV) cnt_q <= cnt_q + SW'(1);
			else cnt_q <= '0;
		end
	end

	always_comb begin
		st_d = st_q;
		done = 1'b0;
		case (st_q)
			LP_IDLE: if (start) st_d = LP_SETUP;
			LP_SETUP: st_d = LP_PREP;
			LP_PREP: st_d = (dt_q == '0) ? LP_DONE : LP_MUL;
			LP_MUL: if (cnt_q == '1) st_d = LP_DIV;
			LP_DIV: if (cnt_q == '1) st_d = LP_FIN;
			LP_FIN: st_d = LP_DONE;
			LP_DONE: begin
				done = 1'b1;
				st_d = LP_IDLE;
			end
			default: st_d = LP_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			LP_IDLE: if (start) begin
				y0_q <= y0;
				y1_q <= y1;
				t0_q <= t0;
				t1_q <= t1;
				tm_q <= tm;
			end
			LP_SETUP: begin
				dt_q <= t1_q - t0_q;
				dm_q <= tm_q - t0_q;
				dy_q <= {y1_q[Y_W-1], y1_q} - {y0_q[Y_W-1], y0_q};
			end
			LP_PREP: begin
				p_q   <= {{TIME_W{1'b0}}, (dm_q > dt_q) ? dt_q : dm_q};
				neg_q <= dy_q[Y_W];
				mag_q <= dy_q[Y_W] ? TIME_W'(-dy_q) : dy_q[TIME_W-1:0];
				v_q   <= y0_q;
			end
			LP_MUL: p_q <= {msum, p_q[TIME_W-1:1]};
			LP_DIV: begin
				if (dge) p_q <= {TIME_W'(dtrial - {1'b0, dt_q}), p_q[TIME_W-2:0], 1'b1};
				else p_q <= {dtrial[TIME_W-1:0], p_q[TIME_W-2:0], 1'b0};
			end
			LP_FIN: begin
				if (neg_q) v_q <= y0_q - {1'b0, p_q[TIME_W-1:0]};
				else v_q <= y0_q + {1'b0, p_q[TIME_W-1:0]};
			end
			default: ;
		endcase
	end

	assign v = v_q;

endmodule

>>> hw/rtl/waveform_grid_minimizer.sv
// waveform_grid_minimizer: sample loader, keep-sample selection, mask word output
// load: one sample per cycle into the sample memory while idle; after the last sample the
// selection runs: a keep-flag clear sweep over ceil(n/64) mask words, then coarse and fine
// passes, each interpolation test using the shared multiply/divide unit; each mask
// word is then read, loaded and held until the output takes it
// reset clears control state, tolerances return to 168; sample memory is undefined
module waveform_grid_minimizer #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  wgm_pkg::wgm_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output wgm_pkg::wgm_out_t                   out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wgm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wgm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import wgm_pkg::*;

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int VW  = (AW + 3 > 6) ? AW + 3 : 7;
	localparam int WD  = (MAX_SAMPLES + 63) / 64;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

	// control state
	wgm_state_t st_q, st_d, ret_q, ret_d;
	logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, ktot_q, ktot_d;
	logic [VW-1:0] wi_q, wi_d, i0_q, i0_d, i1_q, i1_d, i_q, i_d, g_q, g_d;
	logic [VW-1:0] lo_q, lo_d, hi_q, hi_d, inc_q, inc_d, m_q, m_d, j_q, j_d, mk_q, mk_d;
	logic out_valid_q, out_valid_d;

	// memories
	wgm_samp_t samp_mem [MAX_SAMPLES];
	logic [MASK_W-1:0] keep_mem [WD];
	wgm_samp_t sm_rd_q;
	logic [MASK_W-1:0] km_rd_q;
	logic sm_we, sm_re, km_we, km_re;
	logic [AW-1:0] sm_raddr;
	logic [WAW-1:0] km_raddr, km_waddr;
	logic [MASK_W-1:0] km_wdata;

	always_ff @(posedge clk) begin
		if (sm_we) samp_mem[cnt_q[AW-1:0]] <= '{in_data.sample_time, in_data.amplitude,
			in_data.phase};
		if (sm_re) sm_rd_q <= samp_mem[sm_raddr];
	end

	always_ff @(posedge clk) begin
		if (km_we) keep_mem[km_waddr] <= km_wdata;
		if (km_re) km_rd_q <= keep_mem[km_raddr];
	end

	// config
	logic [AMP_W-1:0] amp_tol_q;
	logic [PTOL_W-1:0] phase_tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_tol_q   <= AMP_W'(TOL_RESET);
			phase_tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_AMP_TOL) amp_tol_q <= cfg_data[AMP_W-1:0];
			if (cfg_index == CFG_PHASE_TOL) phase_tol_q <= cfg_data[PTOL_W-1:0];
		end
	end

	// datapath
	logic [AW-1:0] ea_q, ea_d, eb_q, eb_d, ek_q, ek_d;
	logic amode_q, amode_d, bad_q, bad_d;
	wgm_samp_t sa_q, sa_d, sb_q, sb_d, sk_q, sk_d;
	logic [AMP_W-1:0] aerr_q, aerr_d;
	logic [2*AMP_W-1:0] aprod_q, aprod_d;
	wgm_out_t out_q, out_d;

	// interpolation unit
	logic lp_start, lp_amp, lp_done;
	logic signed [Y_W-1:0] lp_y0, lp_y1, lp_v;

	assign lp_y0 = lp_amp ? {{(Y_W-AMP_W){1'b0}}, sa_q.amplitude}
		: {sa_q.phase[PHASE_W-1], sa_q.phase};
	assign lp_y1 = lp_amp ? {{(Y_W-AMP_W){1'b0}}, sb_q.amplitude}
		: {sb_q.phase[PHASE_W-1], sb_q.phase};

	wgm_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lp_start),
		.y0     (lp_y0),
		.y1     (lp_y1),
		.t0     (sa_q.sample_time),
		.t1     (sb_q.sample_time),
		.tm     (sk_q.sample_time),
		.done   (lp_done),
		.v      (lp_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ret_q       <= ST_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			ktot_q      <= '0;
			wi_q        <= '0;
			i0_q        <= '0;
			i1_q        <= '0;
			i_q         <= '0;
			g_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			inc_q       <= '0;
			m_q         <= '0;
			j_q         <= '0;
			mk_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			ret_q       <= ret_d;
			cnt_q       <= cnt_d;
			n_q         <= n_d;
			ktot_q      <= ktot_d;
			wi_q        <= wi_d;
			i0_q        <= i0_d;
			i1_q        <= i1_d;
			i_q         <= i_d;
			g_q         <= g_d;
			lo_q        <= lo_d;
			hi_q        <= hi_d;
			inc_q       <= inc_d;
			m_q         <= m_d;
			j_q         <= j_d;
			mk_q        <= mk_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ea_q    <= ea_d;
		eb_q    <= eb_d;
		ek_q    <= ek_d;
		amode_q <= amode_d;
		bad_q   <= bad_d;
		sa_q    <= sa_d;
		sb_q    <= sb_d;
		sk_q    <= sk_d;
		aerr_q  <= aerr_d;
		aprod_q <= aprod_d;
		out_q   <= out_d;
	end

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		logic [VW-1:0] last, nw, g1, g2, ng, nm, inc2, mid_b, mark_idx;
		logic [CW-1:0] cnt_n;
		logic call_mid, call_mark;
		wgm_state_t mid_ret, mark_ret;
		logic signed [Y_W:0] pe, ae, pabs, aabs;

		last      = VW'(n_q) - VW'(1);
		nw        = (VW'(n_q) + VW'(63)) >> 6;
		g1        = '0;
		g2        = '0;
		ng        = '0;
		nm        = '0;
		inc2      = inc_q << 1;
		mid_b     = '0;
		mark_idx  = '0;
		cnt_n     = cnt_q;
		call_mid  = 1'b0;
		call_mark = 1'b0;
		mid_ret   = ST_IDLE;
		mark_ret  = ST_IDLE;
		pe        = {lp_v[Y_W-1], lp_v} - {{2{sk_q.phase[PHASE_W-1]}}, sk_q.phase};
		pabs      = pe[Y_W] ? -pe : pe;
		ae        = {lp_v[Y_W-1], lp_v} - {{(Y_W+1-AMP_W){1'b0}}, sk_q.amplitude};
		aabs      = ae[Y_W] ? -ae : ae;

		st_d        = st_q;
		ret_d       = ret_q;
		cnt_d       = cnt_q;
		n_d         = n_q;
		ktot_d      = ktot_q;
		wi_d        = wi_q;
		i0_d        = i0_q;
		i1_d        = i1_q;
		i_d         = i_q;
		g_d         = g_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		inc_d       = inc_q;
		m_d         = m_q;
		j_d         = j_q;
		mk_d        = mk_q;
		out_valid_d = out_valid_q;
		ea_d        = ea_q;
		eb_d        = eb_q;
		ek_d        = ek_q;
		amode_d     = amode_q;
		bad_d       = bad_q;
		sa_d        = sa_q;
		sb_d        = sb_q;
		sk_d        = sk_q;
		aerr_d      = aerr_q;
		aprod_d     = aprod_q;
		out_d       = out_q;

		sm_we    = 1'b0;
		sm_re    = 1'b0;
		sm_raddr = '0;
		km_we    = 1'b0;
		km_re    = 1'b0;
		km_raddr = '0;
		km_waddr = '0;
		km_wdata = '0;
		lp_start = 1'b0;
		lp_amp   = 1'b0;

		case (st_q)
			ST_IDLE: if (in_valid) begin
				if (cnt_q < CW'(MAX_SAMPLES)) begin
					sm_we = 1'b1;
					cnt_n = cnt_q + CW'(1);
				end
				if (in_data.last_sample) begin
					n_d    = cnt_n;
					cnt_d  = '0;
					ktot_d = '0;
					wi_d   = '0;
					st_d   = ST_CLR;
				end else begin
					cnt_d = cnt_n;
				end
			end
			ST_CLR: begin
				km_we    = 1'b1;
				km_waddr = WAW'(wi_q);
				if (wi_q + VW'(1) == nw) begin
					wi_d = '0;
					st_d = ST_MK0;
				end else begin
					wi_d = wi_q + VW'(1);
				end
			end
			ST_MK0: begin
				call_mark = 1'b1;
				mark_ret  = ST_MKL;
			end
			ST_MKL: begin
				call_mark = 1'b1;
				mark_idx  = last;
				mark_ret  = (n_q < CW'(3)) ? ST_O_RD : ST_C_INIT;
			end
			ST_MK_RD: begin
				km_re    = 1'b1;
				km_raddr = WAW'(mk_q >> 6);
				st_d     = ST_MK_WR;
			end
			ST_MK_WR: begin
				if (!km_rd_q[mk_q[5:0]]) begin
					km_we    = 1'b1;
					km_waddr = WAW'(mk_q >> 6);
					km_wdata = km_rd_q | (MASK_W'(1) << mk_q[5:0]);
					ktot_d   = ktot_q + CW'(1);
				end
				st_d = ret_q;
			end
			// coarse pass
			ST_C_INIT: begin
				i0_d = '0;
				g_d  = last >> 1;
				st_d = ST_C_LOOP;
			end
			ST_C_LOOP: begin
				if ((i0_q < last) && (((i0_q + g_q) >> 1) < last)) begin
					g1       = (g_q > last) ? last : g_q;
					g2       = (g1 < i0_q + VW'(1)) ? i0_q + VW'(1) : g1;
					inc_d    = VW'(1);
					lo_d     = g2;
					hi_d     = g2 + VW'(1);
					call_mid = 1'b1;
					mid_b    = g2;
					mid_ret  = ST_H_A;
				end else begin
					st_d = ST_F_INIT;
				end
			end
			ST_H_A: begin
				if (!bad_q) begin
					st_d = ST_H_UPCHK;
				end else if (lo_q <= i0_q + VW'(2)) begin
					j_d       = i0_q + VW'(2);
					call_mark = 1'b1;
					mark_idx  = i0_q + VW'(2);
					mark_ret  = ST_C_NEXT;
				end else begin
					hi_d     = lo_q;
					lo_d     = lo_q - VW'(1);
					call_mid = 1'b1;
					mid_b    = lo_q - VW'(1);
					mid_ret  = ST_H_DN;
				end
			end
			ST_H_UPCHK: begin
				if (hi_q <= last) begin
					call_mid = 1'b1;
					mid_b    = hi_q;
					mid_ret  = ST_H_UP;
				end else begin
					hi_d = VW'(n_q);
					st_d = ST_H_BIS;
				end
			end
			ST_H_UP: begin
				if (!bad_q) begin
					lo_d  = hi_q;
					inc_d = inc2;
					hi_d  = hi_q + inc2;
					st_d  = ST_H_UPCHK;
				end else begin
					st_d = ST_H_BIS;
				end
			end
			ST_H_DN: begin
				if (!bad_q) begin
					st_d = ST_H_BIS;
				end else begin
					hi_d = lo_q;
					if (lo_q <= i0_q + VW'(2)) begin
						j_d       = i0_q + VW'(2);
						call_mark = 1'b1;
						mark_idx  = i0_q + VW'(2);
						mark_ret  = ST_C_NEXT;
					end else begin
						inc_d = inc2;
						if (lo_q < i0_q + VW'(2) + inc2) begin
							lo_d = i0_q + VW'(2);
							st_d = ST_H_BIS;
						end else begin
							lo_d     = lo_q - inc2;
							call_mid = 1'b1;
							mid_b    = lo_q - inc2;
							mid_ret  = ST_H_DN;
						end
					end
				end
			end
			ST_H_BIS: begin
				if (hi_q - lo_q != VW'(1)) begin
					m_d      = (hi_q + lo_q) >> 1;
					call_mid = 1'b1;
					mid_b    = (hi_q + lo_q) >> 1;
					mid_ret  = ST_H_BM;
				end else begin
					j_d       = lo_q;
					call_mark = 1'b1;
					mark_idx  = lo_q;
					mark_ret  = ST_C_NEXT;
				end
			end
			ST_H_BM: begin
				if (!bad_q) lo_d = m_q;
				else hi_d = m_q;
				st_d = ST_H_BIS;
			end
			ST_C_NEXT: begin
				ng   = j_q + (j_q - i0_q);
				i0_d = j_q;
				g_d  = (ng < j_q + VW'(2)) ? j_q + VW'(2) : ng;
				st_d = ST_C_LOOP;
			end
			// fine pass
			ST_F_INIT: begin
				i0_d = '0;
				i1_d = VW'(1);
				i_d  = VW'(1);
				st_d = ST_F_TOP;
			end
			ST_F_TOP: begin
				if (i_q >= VW'(n_q)) begin
					st_d = ST_O_RD;
				end else if (i_q > i1_q) begin
					i1_d = i_q;
					i0_d = i_q;
					st_d = ST_F_BKCHK;
				end else begin
					st_d = ST_F_FWCHK;
				end
			end
			ST_F_BKCHK: begin
				if (i0_q == '0) begin
					st_d = ST_F_FWCHK;
				end else begin
					km_re    = 1'b1;
					km_raddr = WAW'(i0_q >> 6);
					st_d     = ST_F_BK;
				end
			end
			ST_F_BK: begin
				if (km_rd_q[i0_q[5:0]]) begin
					st_d = ST_F_FWCHK;
				end else begin
					i0_d = i0_q - VW'(1);
					st_d = ST_F_BKCHK;
				end
			end
			ST_F_FWCHK: begin
				if (i1_q < last) begin
					km_re    = 1'b1;
					km_raddr = WAW'(i1_q >> 6);
					st_d     = ST_F_FW;
				end else begin
					st_d = ST_F_TEST;
				end
			end
			ST_F_FW: begin
				if (km_rd_q[i1_q[5:0]]) begin
					st_d = ST_F_TEST;
				end else begin
					i1_d = i1_q + VW'(1);
					st_d = ST_F_FWCHK;
				end
			end
			ST_F_TEST: begin
				if (i_q != i0_q && i_q != i1_q) begin
					ea_d    = AW'(i0_q);
					eb_d    = AW'(i1_q);
					ek_d    = AW'(i_q);
					amode_d = 1'b1;
					ret_d   = ST_F_RES;
					st_d    = ST_E_RA;
				end else begin
					st_d = ST_F_ADV;
				end
			end
			ST_F_RES: begin
				if (bad_q) begin
					nm        = (i0_q + i1_q) >> 1;
					i1_d      = nm;
					call_mark = 1'b1;
					mark_idx  = nm;
					mark_ret  = ST_F_TOP;
				end else begin
					st_d = ST_F_ADV;
				end
			end
			ST_F_ADV: begin
				if (i_q == i1_q) begin
					i0_d = i1_q;
					i1_d = i1_q + VW'(1);
				end
				i_d  = i_q + VW'(1);
				st_d = ST_F_TOP;
			end
			// interpolation test of sample ek between ea and eb
			ST_E_RA: begin
				sm_re    = 1'b1;
				sm_raddr = ea_q;
				st_d     = ST_E_RB;
			end
			ST_E_RB: begin
				sa_d     = sm_rd_q;
				sm_re    = 1'b1;
				sm_raddr = eb_q;
				st_d     = ST_E_RK;
			end
			ST_E_RK: begin
				sb_d     = sm_rd_q;
				sm_re    = 1'b1;
				sm_raddr = ek_q;
				st_d     = ST_E_K;
			end
			ST_E_K: begin
				sk_d = sm_rd_q;
				st_d = ST_E_PS;
			end
			ST_E_PS: begin
				lp_start = 1'b1;
				st_d     = ST_E_PW;
			end
			ST_E_PW: if (lp_done) st_d = ST_E_PH;
			ST_E_PH: begin
				bad_d = pabs > {{(Y_W+1-PTOL_W){1'b0}}, phase_tol_q};
				if (amode_q) begin
					lp_start = 1'b1;
					lp_amp   = 1'b1;
					st_d     = ST_E_AW;
				end else begin
					st_d = ret_q;
				end
			end
			ST_E_AW: if (lp_done) st_d = ST_E_AM1;
			ST_E_AM1: begin
				aerr_d  = aabs[AMP_W-1:0];
				aprod_d = amp_tol_q * sk_q.amplitude;
				st_d    = ST_E_AM2;
			end
			ST_E_AM2: begin
				if ({aerr_q, {AMP_W{1'b0}}} > aprod_q) bad_d = 1'b1;
				st_d = ret_q;
			end
			// mask word output
			ST_O_RD: begin
				km_re    = 1'b1;
				km_raddr = WAW'(wi_q);
				st_d     = ST_O_LD;
			end
			ST_O_LD: begin
				out_d.keep_mask       = km_rd_q;
				out_d.mask_word_index = wi_q[WIDX_W-1:0];
				out_d.kept_count      = KCNT_W'(ktot_q);
				out_d.last_word       = (wi_q + VW'(1) == nw);
				out_valid_d           = 1'b1;
				st_d                  = ST_O_HOLD;
			end
			ST_O_HOLD: if (out_ready) begin
				out_valid_d = 1'b0;
				if (out_q.last_word) begin
					st_d = ST_IDLE;
				end else begin
					wi_d = wi_q + VW'(1);
					st_d = ST_O_RD;
				end
			end
			default: st_d = ST_IDLE;
		endcase

		// midpoint phase check of interval i0..mid_b
		if (call_mid) begin
			ea_d    = AW'(i0_q);
			eb_d    = AW'(mid_b);
			ek_d    = AW'((i0_q + mid_b) >> 1);
			amode_d = 1'b0;
			if (mid_b == i0_q + VW'(1)) begin
				bad_d = 1'b0;
				st_d  = mid_ret;
			end else begin
				ret_d = mid_ret;
				st_d  = ST_E_RA;
			end
		end

		if (call_mark) begin
			mk_d  = mark_idx;
			ret_d = mark_ret;
			st_d  = ST_MK_RD;
		end
	end

endmodule

>>> verif/waveform_grid_minimizer_check.sv
`timescale 1ns / 1ps
// waveform_grid_minimizer_check: watches the sample, config and mask word channels,
// predicts the keep masks of each set and compares every output transfer
// depends on wgm_pkg for the payload structs and config register codes
module waveform_grid_minimizer_check #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  wgm_pkg::wgm_in_t                   in_data,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  wgm_pkg::wgm_out_t                  out_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [wgm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wgm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                 fails,
	output int                                 pending
);
	import wgm_pkg::*;

	logic [TIME_W-1:0]         time_mem  [MAX_SAMPLES];
	logic [AMP_W-1:0]          amp_mem   [MAX_SAMPLES];
	logic signed [PHASE_W-1:0] phase_mem [MAX_SAMPLES];
	bit                        kept      [MAX_SAMPLES];
	int unsigned               fill;
	int unsigned               kept_total;
	logic [AMP_W-1:0]          amp_limit;
	logic [PTOL_W-1:0]         phase_limit;
	wgm_out_t                  mask_words [$];

	assign pending = mask_words.size();

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fails++;
	endtask

	function automatic longint interp(input longint y0, input longint y1,
			input logic [31:0] x0, input logic [31:0] x1, input logic [31:0] xm);
		logic [31:0] dt;
		logic [31:0] dm;
		longint dy;
		longint unsigned mag;
		longint unsigned q;
		dt = x1 - x0;
		dm = xm - x0;
		if (dt == 0) return y0;
		if (dm > dt) dm = dt;
		dy = y1 - y0;
		mag = (dy < 0) ? longint'(-dy) : dy;
		q = mag * {32'd0, dm} / {32'd0, dt};
		return (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
	endfunction

	function automatic bit phase_off(input int unsigned a, input int unsigned b,
			input int unsigned k);
		longint v;
		longint e;
		v = interp(longint'(phase_mem[a]), longint'(phase_mem[b]), time_mem[a],
			time_mem[b], time_mem[k]);
		e = v - longint'(phase_mem[k]);
		if (e < 0) e = -e;
		return e > longint'({1'b0, phase_limit});
	endfunction

	function automatic bit amp_off(input int unsigned a, input int unsigned b,
			input int unsigned k);
		longint v;
		longint e;
		longint unsigned lhs;
		longint unsigned rhs;
		v = interp(longint'({1'b0, amp_mem[a]}), longint'({1'b0, amp_mem[b]}),
			time_mem[a], time_mem[b], time_mem[k]);
		e = v - longint'({1'b0, amp_mem[k]});
		if (e < 0) e = -e;
		lhs = longint'(e) << 24;
		rhs = longint'({1'b0, amp_limit}) * longint'({1'b0, amp_mem[k]});
		return lhs > rhs;
	endfunction

	function automatic bit mid_fits(input int unsigned a, input int unsigned b);
		if (b == a + 1) return 1'b1;
		return !phase_off(a, b, (a + b) >> 1);
	endfunction

	function automatic int unsigned hunt(input int unsigned n, input int unsigned i0,
			input int unsigned g);
		int unsigned last;
		int unsigned inc;
		int unsigned lo;
		int unsigned hi;
		int unsigned m;
		last = n - 1;
		inc = 1;
		lo = g;
		hi = g + 1;
		if (mid_fits(i0, lo)) begin
			while (hi <= last && mid_fits(i0, hi)) begin
				lo = hi;
				inc <<= 1;
				hi += inc;
			end
			if (hi > last) hi = n;
		end else begin
			if (lo <= i0 + 2) return i0 + 2;
			hi = lo;
			lo = lo - 1;
			while (!mid_fits(i0, lo)) begin
				hi = lo;
				if (hi <= i0 + 2) return i0 + 2;
				inc <<= 1;
				if (hi < i0 + 2 + inc) begin
					lo = i0 + 2;
					break;
				end
				lo = hi - inc;
			end
		end
		while (hi - lo != 1) begin
			m = (hi + lo) >> 1;
			if (mid_fits(i0, m)) lo = m;
			else hi = m;
		end
		return lo;
	endfunction

	function automatic void keep(input int unsigned k);
		if (!kept[k]) begin
			kept[k] = 1'b1;
			kept_total++;
		end
	endfunction

	function automatic void choose_samples(input int unsigned n);
		int unsigned last;
		int unsigned i0;
		int unsigned i1;
		int unsigned g;
		int unsigned i;
		int unsigned j;
		int unsigned ng;
		last = n - 1;
		foreach (kept[k]) kept[k] = 1'b0;
		kept_total = 0;
		keep(0);
		keep(last);
		if (n < 3) return;
		i0 = 0;
		g = last >> 1;
		while (i0 < last && ((i0 + g) >> 1) < last) begin
			if (g > last) g = last;
			if (g < i0 + 1) g = i0 + 1;
			j = hunt(n, i0, g);
			keep(j);
			ng = j + (j - i0);
			if (ng < j + 2) ng = j + 2;
			i0 = j;
			g = ng;
		end
		i0 = 0;
		i1 = 1;
		i = 1;
		while (i < n) begin
			if (i > i1) begin
				i1 = i;
				i0 = i;
				while (i0 > 0 && !kept[i0]) i0--;
			end
			while (i1 < last && !kept[i1]) i1++;
			if (i != i0 && i != i1) begin
				if (amp_off(i0, i1, i) || phase_off(i0, i1, i)) begin
					i1 = (i0 + i1) >> 1;
					keep(i1);
					continue;
				end
			end
			if (i == i1) begin
				i0 = i1;
				i1++;
			end
			i++;
		end
	endfunction

	function automatic void predict_masks();
		int unsigned words;
		wgm_out_t w;
		choose_samples(fill);
		words = (fill + 63) / 64;
		for (int unsigned wi = 0; wi < words; wi++) begin
			w = '0;
			for (int unsigned b = 0; b < 64; b++)
				if (wi * 64 + b < fill && kept[wi * 64 + b]) w.keep_mask[b] = 1'b1;
			w.mask_word_index = wi[WIDX_W-1:0];
			w.kept_count = kept_total[KCNT_W-1:0];
			w.last_word = (wi + 1 == words);
			mask_words = {mask_words, w};
		end
		fill = 0;
	endfunction

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		wgm_out_t want;
		if (!arst_n) begin
			amp_limit <= TOL_RESET[AMP_W-1:0];
			phase_limit <= TOL_RESET;
			fill = 0;
			mask_words.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_AMP_TOL) amp_limit <= cfg_data[AMP_W-1:0];
				else if (cfg_index == CFG_PHASE_TOL) phase_limit <= cfg_data[PTOL_W-1:0];
			end
			if (in_valid && in_ready) begin
				if (fill < MAX_SAMPLES) begin
					time_mem[fill] = in_data.sample_time;
					amp_mem[fill] = in_data.amplitude;
					phase_mem[fill] = in_data.phase;
					fill++;
				end
				if (in_data.last_sample) predict_masks();
			end
			if (out_valid && out_ready) begin
				if (mask_words.size() == 0) begin
					report("mask word transfer with nothing expected");
				end else begin
					want = mask_words.pop_front();
					if (out_data.keep_mask !== want.keep_mask)
						report($sformatf("keep_mask got %h want %h", out_data.keep_mask,
							want.keep_mask));
					if (out_data.mask_word_index !== want.mask_word_index)
						report($sformatf("mask_word_index got %0d want %0d",
							out_data.mask_word_index, want.mask_word_index));
					if (out_data.kept_count !== want.kept_count)
						report($sformatf("kept_count got %0d want %0d",
							out_data.kept_count, want.kept_count));
					if (out_data.last_word !== want.last_word)
						report($sformatf("last_word got %b want %b", out_data.last_word,
							want.last_word));
				end
			end
		end
	end

endmodule

>>> verif/waveform_grid_minimizer_test.sv
`timescale 1ns / 1ps
// waveform_grid_minimizer_test: drives sample sets and tolerance writes into the block
// with random idling on both sides unless steady; the checker predicts and compares
// depends on wgm_pkg, waveform_grid_minimizer and waveform_grid_minimizer_check
module waveform_grid_minimizer_test;
	import wgm_pkg::*;

	localparam int MAX_SAMPLES = 4096;
	localparam int CYCLE_LIMIT = 30000000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	wgm_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	wgm_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fails;
	int                    pending;
	int                    cycles = 0;
	int                    sent = 0;
	bit                    steady = 1'b0;

	waveform_grid_minimizer #(.MAX_SAMPLES(MAX_SAMPLES)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	waveform_grid_minimizer_check #(.MAX_SAMPLES(MAX_SAMPLES)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fails(fails), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_sample(input logic [31:0] stamp, input logic [23:0] amp,
			input logic [31:0] ph, input logic fin);
		if (!steady)
			while ($urandom_range(99) < 26) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		in_data <= '{sample_time: stamp, amplitude: amp, phase: ph, last_sample: fin};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// increasing times, drifting phase with jitter and jumps, amplitude near a level or at times zero
	task automatic smooth_set(input int n);
		logic [31:0] stamp;
		logic [31:0] ph;
		int slope;
		int level;
		int amp;
		stamp = $urandom_range(0, 1 << 20);
		ph = $urandom;
		slope = int'($urandom_range(0, 1 << 21)) - (1 << 20);
		level = $urandom_range(1 << 20, (1 << 24) - (1 << 13));
		for (int i = 0; i < n; i++) begin
			stamp += $urandom_range(1, 1 << 16);
			ph += slope + int'($urandom_range(0, 255)) - 128;
			if ($urandom_range(9) == 0) ph += int'($urandom_range(0, 1 << 25)) - (1 << 24);
			amp = level + int'($urandom_range(0, 1 << 13)) - (1 << 12);
			if ($urandom_range(29) == 0) amp = 0;
			send_sample(stamp, amp[23:0], ph, i == n - 1);
		end
	endtask

	task automatic noise_set(input int n);
		for (int i = 0; i < n; i++)
			send_sample($urandom, $urandom, $urandom, i == n - 1);
	endtask

	initial begin
		logic [31:0] ptol;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one and two sample sets, all kept; extremes of every field
		send_sample(32'd0, 24'd0, 32'd0, 1'b1);
		send_sample(32'hFFFF_FFFF, 24'hFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_sample(32'd0, 24'd0, 32'h8000_0000, 1'b1);
		// zero time span and zero amplitude
		send_sample(32'd100, 24'd0, 32'd0, 1'b0);
		send_sample(32'd100, 24'd5, 32'h0100_0000, 1'b0);
		send_sample(32'd100, 24'd0, 32'h8000_0000, 1'b0);
		send_sample(32'd100, 24'hFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_sample(32'd100, 24'd0, 32'd0, 1'b1);
		// times out of order
		send_sample(32'd50, 24'd1000, 32'd0, 1'b0);
		send_sample(32'd10, 24'd2000, 32'd1000, 1'b0);
		send_sample(32'd90, 24'd10, 32'hFFFF_0000, 1'b0);
		send_sample(32'd20, 24'd0, 32'd12345, 1'b0);
		send_sample(32'd30, 24'd700, 32'd0, 1'b0);
		send_sample(32'd5, 24'd900, 32'd99, 1'b1);
		// steep phase step that stops the hunt's growth and makes it bisect
		for (int i = 0; i < 10; i++)
			send_sample(32'd1000 * i, 24'h40_0000, (i < 7) ? 32'd0 : 32'h2000_0000, i == 9);
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					write_reg(CFG_AMP_TOL, 32'd0);
					write_reg(CFG_PHASE_TOL, 32'd0);
				end
				1: begin
					write_reg(CFG_AMP_TOL, 32'hFFFF_FFFF);
					write_reg(CFG_PHASE_TOL, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(CFG_AMP_TOL, 32'h0000_4000);
					write_reg(CFG_PHASE_TOL, 32'h0010_0000);
					write_reg(2'd2, $urandom);
					write_reg(2'd3, $urandom);
					steady = 1'b1;
				end
				default: begin
					ptol = $urandom >> $urandom_range(0, 31);
					write_reg(CFG_AMP_TOL, $urandom >> $urandom_range(8, 31));
					write_reg(CFG_PHASE_TOL, ptol);
					steady = 1'b0;
				end
			endcase
			while (sent < 90 * (p + 1) + 25) begin
				case ($urandom_range(9))
					0: noise_set($urandom_range(1, 6));
					1: smooth_set($urandom_range(60, 140));
					default: smooth_set($urandom_range(3, 24));
				endcase
			end
			settle();
		end

		// store full: the final sample is dropped but still starts selection
		write_reg(CFG_AMP_TOL, 32'h0000_8000);
		write_reg(CFG_PHASE_TOL, 32'h0100_0000);
		smooth_set(MAX_SAMPLES + 1);
		settle();
		repeat (50) @(posedge clk);

		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
